>>> rtl/pefr_pkg.sv
// Package of the pointer event FIFO register block: codes, types and defaults.
package pefr_pkg;

  // Default depth of the pointer event queue.
  localparam int QUEUE_DEPTH_DEF = 10;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Register word indexes on the bus side.
  localparam logic [2:0] IDX_CTRL    = 3'd0;
  localparam logic [2:0] IDX_WIDTH   = 3'd1;
  localparam logic [2:0] IDX_HEIGHT  = 3'd2;
  localparam logic [2:0] IDX_X       = 3'd3;
  localparam logic [2:0] IDX_Y       = 3'd4;
  localparam logic [2:0] IDX_BUTTONS = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Bit positions inside the ctrl and button registers.
  localparam int CTRL_ENABLE_BIT = 0;
  localparam int DATA_AVAIL_BIT  = 31;

  // One queued pointer event.
  typedef struct packed {
    logic [7:0]  btn;
    logic [15:0] px;
    logic [15:0] py;
  } evt_entry_t;

  localparam int EVT_W = $bits(evt_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // an item is taken this cycle
    logic pop_start;  // the accepted item pops the queue; fetch the head entry
    logic pop_finish; // the head entry is back from memory; retire the pop
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_needed; // the offered item is a buttons read with events queued
    logic out_free;   // the result register can take a word this cycle
  } dp_status_t;

endpackage

>>> rtl/pefr_in_if.sv
// Input channel interface: one item per word.
interface pefr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic [7:0]  buttons;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, output op, output reg_index, output write_data,
                  output buttons, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input op, input reg_index, input write_data,
                  input buttons, input pos_x, input pos_y, output ready);
endinterface

>>> rtl/pefr_out_if.sv
// Result channel interface: one result per word.
interface pefr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_pulse;

  modport source (output valid, output read_data, output irq_pulse, input ready);
  modport sink   (input valid, input read_data, input irq_pulse, output ready);
endinterface

>>> rtl/pefr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pefr_ctrl.sv
// Controller state machine: sequences item acceptance and queue pops through ST_POP.
module pefr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pefr_pkg::dp_status_t  status,
  output pefr_pkg::ctl_cmd_t    cmd
);
  import pefr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = status.out_free;
        cmd.accept    = in_valid && status.out_free;
        cmd.pop_start = cmd.accept && status.pop_needed;
        if (cmd.pop_start) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        cmd.pop_finish = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/pefr_dp.sv
// Datapath: register file, event queue pointers, queue memory and result register.
module pefr_dp #(
  parameter int QUEUE_DEPTH = pefr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_op,
  input  logic [2:0]           in_reg_index,
  input  logic [31:0]          in_write_data,
  input  logic [7:0]           in_buttons,
  input  logic [15:0]          in_pos_x,
  input  logic [15:0]          in_pos_y,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [31:0]          out_read_data,
  output logic                 out_irq_pulse,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  pefr_pkg::ctl_cmd_t   cmd,
  output pefr_pkg::dp_status_t status
);
  import pefr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [31:0]      ctrl_word_r,   ctrl_word_nxt;
  logic [31:0]      cur_x_r,       cur_x_nxt;
  logic [31:0]      cur_y_r,       cur_y_nxt;
  logic [31:0]      button_word_r, button_word_nxt;
  logic [15:0]      frame_width_r;
  logic [15:0]      frame_height_r;
  logic [PTR_W-1:0] head_r,        head_nxt;
  logic [PTR_W-1:0] tail_r,        tail_nxt;
  logic [CNT_W-1:0] count_r,       count_nxt;
  logic             out_valid_r,   out_valid_nxt;
  logic [31:0]      out_data_r,    out_data_nxt;
  logic             out_irq_r,     out_irq_nxt;

  logic             enabled;
  logic             queue_empty;
  logic [CNT_W-1:0] count_dec;
  logic             mem_we;
  evt_entry_t       mem_wdata;
  evt_entry_t       mem_rdata;
  logic [31:0]      rd_mux;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign enabled     = ctrl_word_r[CTRL_ENABLE_BIT];
  assign queue_empty = (count_r == '0);
  assign count_dec   = count_r - 1'b1;

  assign status.pop_needed = (in_op == OP_READ) && (in_reg_index == IDX_BUTTONS) && !queue_empty;
  assign status.out_free   = !out_valid_r || out_ready;

  assign mem_wdata.btn = in_buttons;
  assign mem_wdata.px  = in_pos_x;
  assign mem_wdata.py  = in_pos_y;
  assign mem_we = cmd.accept && (in_op == OP_EVENT) && enabled && (count_r < CNT_FULL);

  pefr_ram #(
    .WIDTH (EVT_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_evt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_r),
    .wdata (mem_wdata),
    .re    (cmd.pop_start),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (in_reg_index)
      IDX_CTRL:    rd_mux = ctrl_word_r;
      IDX_WIDTH:   rd_mux = {16'd0, frame_width_r};
      IDX_HEIGHT:  rd_mux = {16'd0, frame_height_r};
      IDX_X:       rd_mux = cur_x_r;
      IDX_Y:       rd_mux = cur_y_r;
      IDX_BUTTONS: rd_mux = button_word_r;
      default:     rd_mux = 32'd0;
    endcase
  end

  always_comb begin
    ctrl_word_nxt   = ctrl_word_r;
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    button_word_nxt = button_word_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    out_data_nxt    = out_data_r;
    out_irq_nxt     = out_irq_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    if (cmd.pop_finish) begin
      // The head entry is now in memory read data; retire the pop.
      button_word_nxt = {24'd0, mem_rdata.btn};
      button_word_nxt[DATA_AVAIL_BIT] = (count_dec != '0);
      cur_x_nxt     = {16'd0, mem_rdata.px};
      cur_y_nxt     = {16'd0, mem_rdata.py};
      head_nxt      = ptr_inc(head_r);
      count_nxt     = count_dec;
      out_data_nxt  = button_word_nxt;
      out_irq_nxt   = (count_dec != '0);
      out_valid_nxt = 1'b1;
    end else if (cmd.accept && !cmd.pop_start) begin
      out_data_nxt  = 32'd0;
      out_irq_nxt   = 1'b0;
      out_valid_nxt = 1'b1;
      case (op_t'(in_op))
        OP_EVENT: begin
          if (mem_we) begin
            tail_nxt  = ptr_inc(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_WRITE: begin
          case (in_reg_index)
            IDX_CTRL: begin
              ctrl_word_nxt   = in_write_data;
              head_nxt        = '0;
              tail_nxt        = '0;
              count_nxt       = '0;
              button_word_nxt = 32'd0;
            end
            IDX_X:       cur_x_nxt       = in_write_data;
            IDX_Y:       cur_y_nxt       = in_write_data;
            IDX_BUTTONS: button_word_nxt = in_write_data;
            default: ;
          endcase
        end
        OP_READ: begin
          out_data_nxt = rd_mux;
        end
        OP_TICK: begin
          out_irq_nxt = enabled && !queue_empty;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_word_r    <= 32'd0;
      cur_x_r        <= 32'd0;
      cur_y_r        <= 32'd0;
      button_word_r  <= 32'd0;
      frame_width_r  <= 16'd0;
      frame_height_r <= 16'd0;
      head_r         <= '0;
      tail_r         <= '0;
      count_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      ctrl_word_r   <= ctrl_word_nxt;
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      button_word_r <= button_word_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_irq_r  <= out_irq_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq_pulse = out_irq_r;

endmodule

>>> rtl/pointer_event_fifo_regs_unit.sv
// Top level of the pointer event FIFO register block.
//
//   Channel  | Direction | Handshake        | Word carries
//   ---------+-----------+------------------+---------------------------------------------
//   in_ch    | sink      | valid/ready      | op, reg_index, write_data, buttons, pos_x/y
//   out_ch   | source    | valid/ready      | read_data, irq_pulse
//   cfg_*    | sink      | write enable     | cfg_index selects frame width or height
//
// Every accepted input word produces exactly one result word. Events, writes, ticks
// and reads other than a popping buttons read have their result in the output
// register at the next clock edge. A buttons read that pops the queue goes through
// ST_POP, because the head entry comes from the event memory through its registered
// read port. A new word is accepted when no result is held or the previous result
// is taken in the same cycle, and not during ST_POP; a stalled result holds off input.
// Reset is synchronous and active low; it empties the queue and clears all registers
// but the result data and irq pulse registers. The event memory needs no clearing
// pass, since an entry is only read after it has been written.
module pointer_event_fifo_regs_unit #(
  parameter int QUEUE_DEPTH = pefr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pefr_in_if.sink     in_ch,
  pefr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pefr_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // The controller owns acceptance and the pop sequence.
  pefr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds all registers, the queue and the result register.
  pefr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_ch.op),
    .in_reg_index  (in_ch.reg_index),
    .in_write_data (in_ch.write_data),
    .in_buttons    (in_ch.buttons),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_y      (in_ch.pos_y),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_read_data (out_ch.read_data),
    .out_irq_pulse (out_ch.irq_pulse),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

>>> rtl/pefr_checker.sv
// Port-level checker for the pointer event FIFO register block, with its bind.
module pefr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic [2:0]  in_reg_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_irq_pulse
);
  import pefr_pkg::*;

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_irq_pulse))
    else $error("result changed while stalled");

  // No input word is taken while a stalled result occupies the output register.
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result stalled");

  // Non-read words return zero data in the next cycle.
  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_READ) |=> out_valid && (out_read_data == 32'd0))
    else $error("non-read word returned data");

  // Events and writes never raise the interrupt.
  a_no_irq_evt_wr: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_EVENT || in_op == OP_WRITE) |=> out_valid && !out_irq_pulse)
    else $error("interrupt raised by event or write");

  // A width read returns a 16-bit value.
  a_width_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_READ) && (in_reg_index == IDX_WIDTH)
    |=> out_valid && (out_read_data[31:16] == 16'd0))
    else $error("width read has upper bits set");

endmodule

bind pointer_event_fifo_regs_unit pefr_checker u_pefr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_op         (in_ch.op),
  .in_reg_index  (in_ch.reg_index),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_irq_pulse (out_ch.irq_pulse)
);
